[rtl/pds_pkg.sv]
package pds_pkg;

	localparam int REF_W   = 27;
	localparam int VCO_W   = 30;
	localparam int LIM_W   = 2;
	localparam int TGT_W   = 28;
	localparam int ACH_W   = 30;
	localparam int NCODE_W = 7;
	localparam int DCODE_W = 5;
	localparam int PCODE_W = 2;
	localparam int PST_W   = 4;
	localparam int PT_W    = 31;
	localparam int D_W     = 27;
	localparam int CIDX_W  = 2;
	localparam int CDAT_W  = 30;

	localparam logic [CIDX_W-1:0] CFG_REF = CIDX_W'(0);
	localparam logic [CIDX_W-1:0] CFG_VCO = CIDX_W'(1);
	localparam logic [CIDX_W-1:0] CFG_LIM = CIDX_W'(2);

	localparam logic [REF_W-1:0] REF_RESET = REF_W'(14318180);
	localparam logic [VCO_W-1:0] VCO_RESET = VCO_W'(230000000);
	localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(1);

	localparam int MAX_NUMER_DEF = 128;
	localparam int MIN_DENOM_DEF = 2;
	localparam int MAX_DENOM_DEF = 32;

	// {extra, code} for post divider p
	function automatic logic [PCODE_W:0] post_code(input logic [PST_W-1:0] p);
		logic [PCODE_W:0] r;
		case (p)
			PST_W'(2): r = 3'b001;
			PST_W'(3): r = 3'b010;
			PST_W'(4): r = 3'b011;
			PST_W'(6): r = 3'b110;
			PST_W'(8): r = 3'b111;
			default:   r = 3'b000;
		endcase
		return r;
	endfunction

endpackage

[rtl/pds_mul.sv]
module pds_mul #(
	parameter int AW = 31,
	parameter int BW = 8
) (
	input  logic          clk,
	input  logic [AW-1:0] a,
	input  logic [BW-1:0] b,
	output logic [AW+BW-1:0] prod_q
);
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end
endmodule

[rtl/pds_div.sv]
module pds_div #(
	parameter int AW = 36,
	parameter int RW = 28,
	parameter int CW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [RW-1:0] rem0,
	input  logic [AW-1:0] sh0,
	input  logic [RW-1:0] divisor,
	input  logic [CW-1:0] iters,
	output logic          done,
	output logic [AW-1:0] quo
);
	logic          busy_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [RW-1:0] rem_q, div_q;
	logic [AW-1:0] sh_q;
	logic [RW:0]   trial;
	logic          ge;

	assign trial = {rem_q, sh_q[AW-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem0;
			sh_q  <= sh0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? RW'(trial - {1'b0, div_q}) : trial[RW-1:0];
			sh_q  <= {sh_q[AW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = sh_q;
endmodule

[rtl/pll_divider_search.sv]
// A new start is taken only while idle; busy stays high for the whole search.
// The search uses the single shared multiplier and the one-bit-per-cycle shared divider.
// Reset: asynchronous, active low; config, sequencer and strobe registers return to reset values, sequencer idles.
// The result strobe lasts one cycle; the receiver cannot stall.
module pll_divider_search #(
	parameter int MAX_NUMER = pds_pkg::MAX_NUMER_DEF,
	parameter int MIN_DENOM = pds_pkg::MIN_DENOM_DEF,
	parameter int MAX_DENOM = pds_pkg::MAX_DENOM_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [pds_pkg::TGT_W-1:0]   target_hz,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [pds_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [pds_pkg::CDAT_W-1:0]  cfg_data,
	output logic                        result_valid,
	output logic                        found,
	output logic [pds_pkg::NCODE_W-1:0] numerator_code,
	output logic [pds_pkg::DCODE_W-1:0] denominator_code,
	output logic                        divide_by_2,
	output logic [pds_pkg::PCODE_W-1:0] post_scale_code,
	output logic                        post_scale_extra,
	output logic [pds_pkg::ACH_W-1:0]   achieved_hz
);
	import pds_pkg::*;

	localparam int NW  = $clog2(MAX_NUMER + 1);
	localparam int NDW = $clog2(MAX_DENOM + 1);
	localparam int BW0 = (NW > NDW) ? NW : NDW;
	localparam int BW  = (BW0 > PST_W) ? BW0 : PST_W;
	localparam int PW  = PT_W + BW;
	localparam int AW  = REF_W + NW + 1;
	localparam int RW  = REF_W + 1;
	localparam int CW  = $clog2(AW + 1);
	localparam int LW  = D_W + NDW;

	typedef enum logic [15:0] {
		S_IDLE = 16'h0001, S_P    = 16'h0002, S_CAP  = 16'h0004, S_PT   = 16'h0008,
		S_NMUL = 16'h0010, S_NUM  = 16'h0020, S_DIV  = 16'h0040, S_PROD = 16'h0080,
		S_DIFF = 16'h0100, S_L    = 16'h0200, S_R    = 16'h0400, S_CMP  = 16'h0800,
		S_NEXT = 16'h1000, S_ADEN = 16'h2000, S_ADIV = 16'h4000, S_FIN  = 16'h8000
	} state_t;

	state_t           state_q;
	logic [REF_W-1:0] ref_q;
	logic [VCO_W-1:0] vco_q;
	logic [LIM_W-1:0] lim_q;
	logic [TGT_W-1:0] t_q;
	logic [PST_W-1:0] p_q;
	logic [AW-2:0]    cap_q;
	logic [PT_W-1:0]  pt_q;
	logic [PW-1:0]    num_q;
	logic [NDW-1:0]   n_q, bn_q;
	logic             v_q, bv_q, have_q;
	logic [NW-1:0]    m_q, bm_q;
	logic [AW-1:0]    prod_q, bprod_q;
	logic [D_W-1:0]   d_q, bd_q;
	logic [LW-1:0]    lhs_q;
	logic             res_q;

	logic [PT_W-1:0]  mul_a;
	logic [BW-1:0]    mul_b;
	logic [PW-1:0]    mul_q;

	logic             div_start, div_done;
	logic [RW-1:0]    div_rem0, div_den;
	logic [AW-1:0]    div_sh0, div_quo;
	logic [CW-1:0]    div_iters;

	// post divider choice: t < floor(V/k)  <=>  k*(t+1) <= V
	logic [TGT_W+3:0] t1, k2, k3, k4, k6, k8, vx;
	logic [PST_W-1:0] p_sel;
	assign t1 = (TGT_W+4)'(t_q) + 1'b1;
	assign k2 = t1 << 1;
	assign k3 = t1 + (t1 << 1);
	assign k4 = t1 << 2;
	assign k6 = k3 << 1;
	assign k8 = t1 << 3;
	assign vx = (TGT_W+4)'(vco_q);
	always_comb begin
		if (k8 <= vx)      p_sel = PST_W'(8);
		else if (k6 <= vx) p_sel = PST_W'(6);
		else if (k4 <= vx) p_sel = PST_W'(4);
		else if (k3 <= vx) p_sel = PST_W'(3);
		else if (k2 <= vx) p_sel = PST_W'(2);
		else               p_sel = PST_W'(1);
	end

	// product pt*n is registered during S_NMUL, i.e. it is on mul_q while in S_NUM
	logic [PW-1:0]  capx, cap_lim, x_full, pe, dfull;
	logic           over_lim, use_v2, take_cmp;
	logic [AW-1:0]  x, prodv;
	assign capx     = PW'(cap_q);
	assign cap_lim  = lim_q[1] ? (capx << 1) : capx;
	assign over_lim = mul_q > cap_lim;
	assign use_v2   = mul_q > capx;
	assign x_full   = use_v2 ? (mul_q + PW'(ref_q)) : ((mul_q << 1) + PW'(ref_q));
	assign x        = x_full[AW-1:0];
	assign prodv    = v_q ? {mul_q[AW-2:0], 1'b0} : {1'b0, mul_q[AW-2:0]};
	assign pe       = PW'(prod_q);
	assign dfull    = (num_q > pe) ? (num_q - pe) : (pe - num_q);
	assign take_cmp = lhs_q < mul_q[LW-1:0];

	always_comb begin
		mul_a = PT_W'(ref_q);
		mul_b = BW'(MAX_NUMER);
		case (state_q)
			S_CAP:  begin mul_a = PT_W'(t_q);  mul_b = BW'(p_q); end
			S_NMUL: begin mul_a = pt_q;        mul_b = BW'(n_q); end
			S_DIV:  begin mul_a = PT_W'(ref_q); mul_b = BW'(div_quo[NW-1:0]); end
			S_L:    begin mul_a = PT_W'(d_q);  mul_b = BW'(bn_q); end
			S_R:    begin mul_a = PT_W'(bd_q); mul_b = BW'(n_q); end
			S_NEXT: begin mul_a = PT_W'(bn_q); mul_b = BW'(p_q); end
			default: begin mul_a = PT_W'(ref_q); mul_b = BW'(MAX_NUMER); end
		endcase
	end

	pds_mul #(.AW(PT_W), .BW(BW)) u_mul (
		.clk(clk), .a(mul_a), .b(mul_b), .prod_q(mul_q)
	);

	assign div_start = ((state_q == S_NUM) && !over_lim) || (state_q == S_ADEN);
	always_comb begin
		if (state_q == S_ADEN) begin
			div_rem0  = '0;
			div_sh0   = bprod_q;
			div_den   = mul_q[RW-1:0];
			div_iters = CW'(AW);
		end else begin
			div_rem0  = x[AW-1:NW];
			div_sh0   = {x[NW-1:0], (AW-NW)'(0)};
			div_den   = {ref_q, 1'b0};
			div_iters = CW'(NW);
		end
	end

	pds_div #(.AW(AW), .RW(RW), .CW(CW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .rem0(div_rem0), .sh0(div_sh0),
		.divisor(div_den), .iters(div_iters), .done(div_done), .quo(div_quo)
	);

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= REF_RESET;
			vco_q <= VCO_RESET;
			lim_q <= LIM_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_REF: ref_q <= cfg_data[REF_W-1:0];
				CFG_VCO: vco_q <= cfg_data[VCO_W-1:0];
				CFG_LIM: lim_q <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			have_q  <= 1'b0;
			res_q   <= 1'b0;
		end else begin
			res_q <= 1'b0;
			case (state_q)
				S_IDLE: if (start) begin
					have_q  <= 1'b0;
					state_q <= (target_hz == '0 || ref_q == '0) ? S_FIN : S_P;
				end
				S_P:    state_q <= S_CAP;
				S_CAP:  state_q <= S_PT;
				S_PT:   state_q <= S_NMUL;
				S_NMUL: state_q <= S_NUM;
				S_NUM:  state_q <= over_lim ? S_NEXT : S_DIV;
				S_DIV:  if (div_done) begin
					state_q <= (div_quo[NW-1:0] == '0) ? S_NEXT : S_PROD;
				end
				S_PROD: state_q <= S_DIFF;
				S_DIFF: state_q <= S_L;
				S_L: begin
					if (!have_q) begin
						have_q  <= 1'b1;
						state_q <= S_NEXT;
					end else begin
						state_q <= S_R;
					end
				end
				S_R:    state_q <= S_CMP;
				S_CMP:  state_q <= S_NEXT;
				S_NEXT: begin
					if (n_q == NDW'(MAX_DENOM)) state_q <= have_q ? S_ADEN : S_FIN;
					else                        state_q <= S_NMUL;
				end
				S_ADEN: state_q <= S_ADIV;
				S_ADIV: if (div_done) state_q <= S_FIN;
				S_FIN: begin
					res_q   <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (start) t_q <= target_hz;
			S_P:    p_q   <= p_sel;
			S_CAP:  cap_q <= mul_q[AW-2:0];
			S_PT: begin
				pt_q <= mul_q[PT_W-1:0];
				n_q  <= NDW'(MIN_DENOM);
			end
			S_NUM: begin
				num_q <= mul_q;
				v_q   <= use_v2;
			end
			S_DIV:  if (div_done) m_q <= div_quo[NW-1:0];
			S_PROD: prod_q <= prodv;
			S_DIFF: d_q <= dfull[D_W-1:0];
			S_L: if (!have_q) begin
				bm_q <= m_q; bn_q <= n_q; bv_q <= v_q; bd_q <= d_q; bprod_q <= prod_q;
			end
			S_R:    lhs_q <= mul_q[LW-1:0];
			S_CMP: if (take_cmp) begin
				bm_q <= m_q; bn_q <= n_q; bv_q <= v_q; bd_q <= d_q; bprod_q <= prod_q;
			end
			S_NEXT: if (n_q != NDW'(MAX_DENOM)) n_q <= n_q + 1'b1;
			default: ;
		endcase
	end

	logic [NW+NCODE_W-1:0]   bm_ext;
	logic [NDW+DCODE_W-1:0]  bn_ext;
	logic [PCODE_W:0]        pc;
	assign bm_ext = (NW+NCODE_W)'(bm_q - 1'b1);
	assign bn_ext = (NDW+DCODE_W)'(bn_q - 1'b1);
	assign pc     = post_code(p_q);

	always_ff @(posedge clk) begin
		if (state_q == S_FIN) begin
			found            <= have_q;
			numerator_code   <= have_q ? bm_ext[NCODE_W-1:0] : '0;
			denominator_code <= have_q ? bn_ext[DCODE_W-1:0] : '0;
			divide_by_2      <= have_q & bv_q;
			post_scale_code  <= have_q ? pc[PCODE_W-1:0] : '0;
			post_scale_extra <= have_q & pc[PCODE_W];
			if (!have_q)                  achieved_hz <= '0;
			else if (|div_quo[AW-1:ACH_W]) achieved_hz <= '1;
			else                          achieved_hz <= div_quo[ACH_W-1:0];
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = res_q;

	a_res_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == S_FIN))
		else $error("result strobe without finish");
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !found) |-> (numerator_code == '0 && denominator_code == '0 &&
		!divide_by_2 && post_scale_code == '0 && !post_scale_extra && achieved_hz == '0))
		else $error("fields not cleared when nothing found");
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("start accepted but block not busy");
	a_cmp_has_best: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> have_q)
		else $error("compare without a best candidate");
endmodule
